### rtl/core/tmtd_pkg.sv
// Package for the tempo map converter: command/status structs, codes, constants.
// Used by tmtd_ctrl, tmtd_datapath and the top level; depends on nothing.
package tmtd_pkg;

    // Fixed point widths
    localparam int TIME_W = 48;            // ms, Q.16, signed
    localparam int COEF_W = 56;            // ms per tick, Q.32, unsigned
    localparam int DVS_W  = 26;            // divisor width
    localparam int DIV_STEPS = COEF_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [15:0] DEFAULT_TICKS = 16'd192;
    localparam logic [COEF_W-1:0] COEF_RESET =
        COEF_W'((64'd500000 << 32) / 64'd192000);

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // Divider operand select
    localparam logic [1:0] DS_DEFAULT = 2'd0;
    localparam logic [1:0] DS_SMPTE   = 2'd1;
    localparam logic [1:0] DS_ENTRY   = 2'd2;

    // Tick span select for scaling
    localparam logic [1:0] TS_SEG   = 2'd0;
    localparam logic [1:0] TS_EVENT = 2'd1;
    localparam logic [1:0] TS_SMPTE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FPS      = 2'd0;
    localparam logic [1:0] CFG_TICKS    = 2'd1;
    localparam logic [1:0] CFG_FALLBACK = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       load_wr;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_step;
        logic       coef_load;
        logic       mem_rd;
        logic       mag_load;
        logic [1:0] tsel;
        logic       mul_lo;
        logic       mul_hi;
        logic       scale;
        logic       acc;
        logic       fin;
        logic       emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic walk_ok;
        logic fps_nz;
    } ctl_stat_t;

    // Saturate a 50-bit signed value to the 48-bit time range
    function automatic logic [TIME_W-1:0] sat_time(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_7FFF_FFFF_FFFF;
        lo = -50'sh0_8000_0000_0000;
        if (v > hi)
            sat_time = hi[TIME_W-1:0];
        else if (v < lo)
            sat_time = lo[TIME_W-1:0];
        else
            sat_time = v[TIME_W-1:0];
    endfunction

endpackage

### rtl/core/tempo_map_tick_to_delta_ms.sv
// Top level of the tempo map converter: ticks to delta milliseconds.
// Instantiates tmtd_ctrl and tmtd_datapath; depends on tmtd_pkg.
//
//  channel   handshake              beat contents
//  input     start & !busy          cmd, first, onset_ticks, tempo_value
//  result    done (one cycle)       delta_ms, status
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
// After the accepting edge a load holds busy for the table write. A metrical
// event holds it for the scaling plus one 56-step divide per tempo change
// walked, and one divide more on the first event of a pass; an SMPTE event
// holds it for one divide and the scaling, one divide more on the first.
// The result shows in the same cycle that busy drops; the receiver cannot stall.
// Reset clears the table count, walk state and registers; no clearing pass.
module tempo_map_tick_to_delta_ms #(
    parameter int TEMPO_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic               first,
    input  logic [31:0]        onset_ticks,
    input  logic [23:0]        tempo_value,
    output logic               done,
    output logic signed [47:0] delta_ms,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import tmtd_pkg::*;

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    tmtd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .first (first),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    tmtd_datapath #(
        .TEMPO_ENTRIES (TEMPO_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .first       (first),
        .onset_ticks (onset_ticks),
        .tempo_value (tempo_value),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .delta_ms    (delta_ms),
        .status      (status)
    );

endmodule

### rtl/core/tmtd_ctrl.sv
// Sequencer for the tempo map converter: walks loads, divisions, scaling.
// Depends on tmtd_pkg; drives tmtd_datapath through command/status structs.
module tmtd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  logic                first,
    input  tmtd_pkg::ctl_stat_t stat,
    output tmtd_pkg::ctl_cmd_t  ctl,
    output logic                busy
);
    import tmtd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_COEF   = 4'd3;
    localparam logic [3:0] S_BRANCH = 4'd4;
    localparam logic [3:0] S_WRD    = 4'd5;
    localparam logic [3:0] S_WCK    = 4'd6;
    localparam logic [3:0] S_MAG    = 4'd7;
    localparam logic [3:0] S_MLO    = 4'd8;
    localparam logic [3:0] S_MHI    = 4'd9;
    localparam logic [3:0] S_SCL    = 4'd10;
    localparam logic [3:0] S_ACC    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] dsel_reg, dsel_next;
    logic [1:0] tsel_reg, tsel_next;

    // State and routing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dsel_reg  <= DS_DEFAULT;
            tsel_reg  <= TS_EVENT;
        end
        else
        begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
            tsel_reg  <= tsel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        dsel_next  = dsel_reg;
        tsel_next  = tsel_reg;
        ctl        = '0;
        ctl.div_sel = dsel_reg;
        ctl.tsel    = tsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch = 1'b1;
                    if (cmd == CMD_LOAD)
                        state_next = S_LOAD;
                    else if (first)
                    begin
                        ctl.div_start = 1'b1;
                        ctl.div_sel   = DS_DEFAULT;
                        dsel_next     = DS_DEFAULT;
                        state_next    = S_DIV;
                    end
                    else
                        state_next = S_BRANCH;
                end
            end
            S_LOAD:
            begin
                ctl.load_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    if (dsel_reg == DS_SMPTE)
                    begin
                        tsel_next  = TS_SMPTE;
                        state_next = S_MAG;
                    end
                    else
                        state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                ctl.coef_load = 1'b1;
                state_next = (dsel_reg == DS_DEFAULT) ? S_BRANCH : S_WRD;
            end
            S_BRANCH:
            begin
                if (stat.fps_nz)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DS_SMPTE;
                    dsel_next     = DS_SMPTE;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_WRD;
            end
            S_WRD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_WCK;
            end
            S_WCK:
            begin
                tsel_next  = stat.walk_ok ? TS_SEG : TS_EVENT;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                ctl.mag_load = 1'b1;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                ctl.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                ctl.mul_hi = 1'b1;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                ctl.scale  = 1'b1;
                state_next = (tsel_reg == TS_SEG) ? S_ACC : S_FIN;
            end
            S_ACC:
            begin
                ctl.acc       = 1'b1;
                ctl.div_start = 1'b1;
                ctl.div_sel   = DS_ENTRY;
                dsel_next     = DS_ENTRY;
                state_next    = S_DIV;
            end
            S_FIN:
            begin
                ctl.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                ctl.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/tmtd_datapath.sv
// Datapath of the tempo map converter: config regs, tempo table, divider,
// shared multiplier, accumulators and result registers. Depends on tmtd_pkg.
module tmtd_datapath #(
    parameter int TEMPO_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tmtd_pkg::ctl_cmd_t  ctl,
    output tmtd_pkg::ctl_stat_t stat,
    input  logic                cmd,
    input  logic                first,
    input  logic [31:0]         onset_ticks,
    input  logic [23:0]         tempo_value,
    input  logic                cfg_wr,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    output logic                done,
    output logic signed [47:0]  delta_ms,
    output logic [1:0]          status
);
    import tmtd_pkg::*;

    localparam int CW = $clog2(TEMPO_ENTRIES + 1);
    localparam int AW = (TEMPO_ENTRIES > 1) ? $clog2(TEMPO_ENTRIES) : 1;
    localparam logic [CW-1:0] ENTRIES = CW'(TEMPO_ENTRIES);

    // Configuration registers
    logic [4:0]  fps_reg;
    logic [15:0] ticks_reg;
    logic [23:0] fallback_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg      <= '0;
            ticks_reg    <= DEFAULT_TICKS;
            fallback_reg <= DEFAULT_TEMPO;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_FPS:      fps_reg      <= cfg_data[4:0];
                CFG_TICKS:    ticks_reg    <= cfg_data[15:0];
                CFG_FALLBACK: fallback_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic fps_nz;
    assign fps_nz = (fps_reg != 5'd0);

    // Latched item
    logic        first_reg;
    logic [31:0] onset_reg;
    logic [23:0] tempo_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            first_reg <= first;
            onset_reg <= onset_ticks;
            tempo_reg <= tempo_value;
        end
    end

    // Tempo table
    logic [31:0] mem_onset [TEMPO_ENTRIES];
    logic [23:0] mem_tempo [TEMPO_ENTRIES];
    logic [31:0] rd_onset_reg;
    logic [23:0] rd_tempo_reg;
    logic [CW-1:0] count_reg, walk_reg;
    logic [CW-1:0] count_eff;
    logic          room;

    assign count_eff = first_reg ? '0 : count_reg;
    assign room      = (count_eff < ENTRIES);

    always_ff @(posedge clk)
    begin
        if (ctl.load_wr && room)
        begin
            mem_onset[count_eff[AW-1:0]] <= onset_reg;
            mem_tempo[count_eff[AW-1:0]] <= tempo_reg;
        end
        if (ctl.mem_rd)
        begin
            rd_onset_reg <= mem_onset[walk_reg[AW-1:0]];
            rd_tempo_reg <= mem_tempo[walk_reg[AW-1:0]];
        end
    end

    // Divider: restoring, one quotient bit per cycle
    logic [COEF_W-1:0] quo_reg;
    logic [DVS_W-1:0]  rem_reg, dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [15:0]       tick_eff;
    logic [23:0]       tempo_eff;
    logic [DVS_W:0]    trial;
    logic              ge;

    assign tick_eff  = (ticks_reg == 16'd0) ? 16'd1 : ticks_reg;
    assign tempo_eff = (rd_tempo_reg != 24'd0) ? rd_tempo_reg :
                       (fallback_reg != 24'd0) ? fallback_reg : DEFAULT_TEMPO;
    assign trial     = {rem_reg, quo_reg[COEF_W-1]};
    assign ge        = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
            case (ctl.div_sel)
                DS_SMPTE:
                begin
                    quo_reg <= COEF_W'(64'd1000 << 32);
                    dvs_reg <= DVS_W'(fps_reg) * DVS_W'(tick_eff);
                end
                DS_ENTRY:
                begin
                    quo_reg <= {tempo_eff, 32'd0};
                    dvs_reg <= DVS_W'(tick_eff) * DVS_W'(1000);
                end
                default:
                begin
                    // Pass start: a set frame rate gives the SMPTE coefficient
                    if (fps_nz)
                    begin
                        quo_reg <= COEF_W'(64'd1000 << 32);
                        dvs_reg <= DVS_W'(fps_reg) * DVS_W'(tick_eff);
                    end
                    else
                    begin
                        quo_reg <= {DEFAULT_TEMPO, 32'd0};
                        dvs_reg <= DVS_W'(tick_eff) * DVS_W'(1000);
                    end
                end
            endcase
        end
        else if (ctl.div_step)
        begin
            rem_reg  <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg  <= {quo_reg[COEF_W-2:0], ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // Walk state and coefficient
    logic [COEF_W-1:0] coef_reg;
    logic [31:0]       change_reg;
    logic [47:0]       elapsed_reg, last_reg, now_reg;
    logic signed [48:0] scaled_reg;

    // Scaling: tick span magnitude, two partial products, saturate
    logic [32:0] mag_reg;
    logic        neg_reg;
    logic [33:0] span;
    logic [COEF_W-1:0] coef_use;
    logic [31:0] mul_b;
    logic [64:0] prod;
    logic [64:0] p_lo_reg;
    logic [56:0] p_hi_reg;
    logic [89:0] full;
    logic [73:0] shifted;
    logic [47:0] lim, p48;

    always_comb
    begin
        case (ctl.tsel)
            TS_SEG:   span = {2'b0, rd_onset_reg} - {2'b0, change_reg};
            TS_SMPTE: span = {2'b0, onset_reg};
            default:  span = {2'b0, onset_reg} - {2'b0, change_reg};
        endcase
    end

    assign coef_use = fps_nz ? quo_reg : coef_reg;
    assign mul_b    = ctl.mul_hi ? {8'd0, coef_use[COEF_W-1:32]} : coef_use[31:0];
    assign prod     = 65'(mag_reg) * 65'(mul_b);
    assign full     = {1'b0, p_hi_reg, 32'd0} + 90'(p_lo_reg);
    assign shifted  = full[89:16];
    assign lim      = neg_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    assign p48      = (shifted > 74'(lim)) ? lim : shifted[47:0];

    always_ff @(posedge clk)
    begin
        if (ctl.mag_load)
        begin
            neg_reg <= span[33];
            mag_reg <= span[33] ? 33'(-span) : span[32:0];
        end
        if (ctl.mul_lo)
            p_lo_reg <= prod;
        if (ctl.mul_hi)
            p_hi_reg <= prod[56:0];
        if (ctl.scale)
            scaled_reg <= neg_reg ? -$signed({1'b0, p48}) : $signed({1'b0, p48});
    end

    // Pass state, final time and result registers
    logic signed [49:0] acc_sum, fin_sum;
    logic signed [49:0] diff;
    logic               back;
    logic [47:0]        now_adj;

    assign acc_sum = 50'($signed(elapsed_reg)) + 50'(scaled_reg);
    assign fin_sum = (fps_nz ? 50'sd0 : 50'($signed(elapsed_reg))) + 50'(scaled_reg);
    assign back    = !fps_nz && ($signed(now_reg) < $signed(last_reg));
    assign now_adj = back ? last_reg : now_reg;
    assign diff    = 50'($signed(now_adj)) - 50'($signed(last_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            walk_reg    <= '0;
            elapsed_reg <= '0;
            change_reg  <= '0;
            last_reg    <= '0;
            coef_reg    <= COEF_RESET;
            done        <= 1'b0;
            delta_ms    <= '0;
            status      <= ST_OK;
        end
        else
        begin
            done <= ctl.load_wr || ctl.emit;
            // Start of an event pass, metrical or SMPTE
            if (ctl.latch && (cmd == CMD_EVENT) && first)
            begin
                walk_reg    <= '0;
                elapsed_reg <= '0;
                change_reg  <= '0;
                last_reg    <= '0;
            end
            if (ctl.load_wr)
            begin
                count_reg <= room ? count_eff + 1'b1 : count_eff;
                delta_ms  <= '0;
                status    <= room ? ST_OK : ST_FULL;
            end
            if (ctl.coef_load)
                coef_reg <= quo_reg;
            if (ctl.acc)
            begin
                elapsed_reg <= sat_time(acc_sum);
                change_reg  <= rd_onset_reg;
                walk_reg    <= walk_reg + 1'b1;
            end
            if (ctl.fin)
                now_reg <= sat_time(fin_sum);
            if (ctl.emit)
            begin
                delta_ms <= $signed(sat_time(diff));
                status   <= back ? ST_CLAMP : ST_OK;
                last_reg <= now_adj;
            end
        end
    end

    // Status back to the sequencer
    assign stat.div_last = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign stat.walk_ok  = (walk_reg < count_reg) && (rd_onset_reg < onset_reg);
    assign stat.fps_nz   = fps_nz;

endmodule

### tb/sv/tempo_map_tick_to_delta_ms_tb.sv
// Testbench for the tempo map converter: directed table, then random load/event sequences.
// Self-checking against a bit-exact predictor of its own; depends on tmtd_pkg and the RTL.
module tempo_map_tick_to_delta_ms_tb;
    import tmtd_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int ITEM_GOAL = 1600;
    localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint T_MIN = -64'sh8000_0000_0000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cmd;
    logic               first;
    logic [31:0]        onset_ticks;
    logic [23:0]        tempo_value;
    logic               done;
    logic signed [47:0] delta_ms;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    typedef struct {
        logic signed [47:0] delta;
        logic [1:0]         st;
    } tempo_result_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [23:0] data;
        bit          c;
        bit          f;
        logic [31:0] onset;
        logic [23:0] tempo;
        bit          typed;
        logic signed [47:0] delta;
        logic [1:0]  st;
    } stim_row_t;

    tempo_result_t pending_results[$];
    stim_row_t     stim_rows[$];
    int            fail_count;
    int            items_sent;
    bit            no_idle;

    // Predictor copy of configuration and walk state
    logic [4:0]  p_fps;
    logic [15:0] p_ticks;
    logic [23:0] p_fallback;
    logic [31:0] p_onsets[TABLE_DEPTH];
    logic [23:0] p_tempos[TABLE_DEPTH];
    int          p_count;
    int          p_walk;
    longint      p_elapsed;
    logic [31:0] p_change;
    logic [63:0] p_coef;
    longint      p_last;

    tempo_map_tick_to_delta_ms i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .first       (first),
        .onset_ticks (onset_ticks),
        .tempo_value (tempo_value),
        .done        (done),
        .delta_ms    (delta_ms),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint clamp_time(input longint v);
        if (v > T_MAX)
            return T_MAX;
        if (v < T_MIN)
            return T_MIN;
        return v;
    endfunction

    // ticks times Q32 coefficient -> Q16 ms, saturated
    function automatic longint ticks_to_ms(input longint tk, input logic [63:0] c);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] lim;
        logic [63:0] p;
        neg = tk < 0;
        mag = neg ? 64'(-tk) : 64'(tk);
        hi  = c >> 32;
        lo  = {32'd0, c[31:0]};
        lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        if (hi != 0 && mag > 64'h7FFF_FFFF / hi)
            p = lim;
        else
        begin
            p = ((mag * hi) << 16) + (({32'd0, mag[31:0]} * lo) >> 16)
                + (((mag >> 32) * lo) << 16);
            if (p > lim)
                p = lim;
        end
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] ms_per_tick(input logic [23:0] tempo);
        logic [63:0] tk;
        logic [63:0] t;
        tk = (p_ticks == 0) ? 64'd1 : 64'(p_ticks);
        if (p_fps != 0)
            return (64'd1000 << 32) / (64'(p_fps) * tk);
        t = 64'(tempo);
        if (t == 0)
            t = 64'(p_fallback);
        if (t == 0)
            t = 64'(DEFAULT_TEMPO);
        return (t << 32) / (tk * 64'd1000);
    endfunction

    // Expected result of one accepted item; updates the predictor state
    task automatic convert_item(input bit c, input bit f, input logic [31:0] onset,
                                input logic [23:0] tempo, output tempo_result_t r);
        longint now;
        r.delta = '0;
        r.st    = ST_OK;
        if (c == CMD_LOAD)
        begin
            if (f)
                p_count = 0;
            if (p_count < TABLE_DEPTH)
            begin
                p_onsets[p_count] = onset;
                p_tempos[p_count] = tempo;
                p_count++;
            end
            else
                r.st = ST_FULL;
        end
        else
        begin
            if (f)
            begin
                p_walk    = 0;
                p_elapsed = 0;
                p_change  = '0;
                p_last    = 0;
                p_coef    = ms_per_tick(DEFAULT_TEMPO);
            end
            if (p_fps != 0)
            begin
                now = ticks_to_ms(longint'(onset), ms_per_tick(24'd0));
                r.delta = 48'(clamp_time(now - p_last));
                p_last = now;
            end
            else
            begin
                while (p_walk < p_count && p_onsets[p_walk] < onset)
                begin
                    p_elapsed = clamp_time(p_elapsed + ticks_to_ms(
                        longint'(p_onsets[p_walk]) - longint'(p_change), p_coef));
                    p_change = p_onsets[p_walk];
                    p_coef   = ms_per_tick(p_tempos[p_walk]);
                    p_walk++;
                end
                now = clamp_time(p_elapsed + ticks_to_ms(
                    longint'(onset) - longint'(p_change), p_coef));
                if (now < p_last)
                begin
                    now  = p_last;
                    r.st = ST_CLAMP;
                end
                r.delta = 48'(clamp_time(now - p_last));
                p_last = now;
            end
        end
    endtask

    // Wait until the block has delivered everything, then a short settle
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FPS:      p_fps = data[4:0];
            CFG_TICKS:    p_ticks = data[15:0];
            CFG_FALLBACK: p_fallback = data;
            default:      ;
        endcase
    endtask

    // One command beat; the expectation is the typed one when given
    task automatic send_item(input bit c, input bit f, input logic [31:0] onset,
                             input logic [23:0] tempo, input bit typed,
                             input tempo_result_t typed_r);
        tempo_result_t r;
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap + 1) @(posedge clk);
        start       <= 1'b1;
        cmd         <= c;
        first       <= f;
        onset_ticks <= onset;
        tempo_value <= tempo;
        do
            @(posedge clk);
        while (busy);
        convert_item(c, f, onset, tempo, r);
        pending_results.push_back(typed ? typed_r : r);
        start <= 1'b0;
        items_sent++;
    endtask

    task automatic add_row(input bit is_cfg, input logic [1:0] idx, input logic [23:0] data,
                           input bit c, input bit f, input logic [31:0] onset,
                           input logic [23:0] tempo, input bit typed,
                           input logic signed [47:0] d, input logic [1:0] st);
        stim_row_t row;
        row.is_cfg = is_cfg;
        row.idx    = idx;
        row.data   = data;
        row.c      = c;
        row.f      = f;
        row.onset  = onset;
        row.tempo  = tempo;
        row.typed  = typed;
        row.delta  = d;
        row.st     = st;
        stim_rows.push_back(row);
    endtask

    function automatic logic [23:0] pick_tempo();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(200000, 1500000));
        endcase
    endfunction

    // Result checker: the receiver never stalls, so every strobe is a result
    always @(posedge clk)
    begin
        tempo_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result delta_ms=%0d status=%0d",
                         $time, delta_ms, status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (delta_ms !== want.delta)
                begin
                    $display("%0t: delta_ms expected %0d actual %0d",
                             $time, want.delta, delta_ms);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #300000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        tempo_result_t tr;
        logic [31:0]   t_onset;
        int            n;
        int            fill;
        fail_count  = 0;
        items_sent  = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = 1'b0;
        first       = 1'b0;
        onset_ticks = '0;
        tempo_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FPS;
        cfg_data    = '0;
        p_fps       = '0;
        p_ticks     = DEFAULT_TICKS;
        p_fallback  = DEFAULT_TEMPO;
        p_count     = 0;
        p_walk      = 0;
        p_elapsed   = 0;
        p_change    = '0;
        p_last      = 0;
        p_coef      = ms_per_tick(DEFAULT_TEMPO);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: empty map, extremes, zero tempo, clamp, tick and SMPTE corners
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd0, 0, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_LOAD, 1, 32'd0, 24'd0, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_LOAD, 0, 32'd192, 24'd1000000, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_LOAD, 0, 32'd384, 24'hFFFFFF, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_LOAD, 0, 32'd1000, 24'd0, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd100, 24'hFFFFFF, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'd500, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'd300, 0, 1, 0, ST_CLAMP);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'hFFFFFFFF, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd0, 0, 1, 0, ST_OK);
        add_row(1, CFG_FALLBACK, 24'd0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd2000, 0, 0, 0, ST_OK);
        add_row(1, CFG_FALLBACK, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd2000, 0, 0, 0, ST_OK);
        add_row(1, CFG_TICKS, 24'd0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd5000, 0, 0, 0, ST_OK);
        add_row(1, CFG_TICKS, 24'd65535, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, CFG_FPS, 24'd30, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'd0, 0, 1, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'd1000, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'd10, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 0, 32'hFFFFFFFF, 0, 0, 0, ST_OK);
        add_row(1, CFG_FPS, 24'd0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, CFG_TICKS, 24'd1, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, CFG_FPS, 0, CMD_EVENT, 1, 32'hFFFFFFFF, 0, 0, 0, ST_OK);
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            else
            begin
                tr.delta = stim_rows[i].delta;
                tr.st    = stim_rows[i].st;
                send_item(stim_rows[i].c, stim_rows[i].f, stim_rows[i].onset,
                          stim_rows[i].tempo, stim_rows[i].typed, tr);
            end
        end

        // Random phases: new settings, a tempo map, then a pass of events
        while (items_sent < ITEM_GOAL)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: write_reg(CFG_FPS, 24'($urandom_range(1, 31)));
                1: write_reg(CFG_FPS, 24'd30);
                default: write_reg(CFG_FPS, 24'd0);
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_TICKS, 24'd1);
                1: write_reg(CFG_TICKS, 24'd65535);
                2: write_reg(CFG_TICKS, 24'($urandom_range(0, 65535)));
                default: write_reg(CFG_TICKS, 24'($urandom_range(24, 960)));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FALLBACK, 24'd0);
                1: write_reg(CFG_FALLBACK, 24'hFFFFFF);
                default: write_reg(CFG_FALLBACK, 24'($urandom));
            endcase

            // Tempo map, mostly sorted; now and then overfilled or unsorted
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 70)
                                               : $urandom_range(0, 8);
            t_onset = $urandom_range(0, 500);
            tr = '{default: '0};
            for (n = 0; n < fill; n++)
            begin
                send_item(CMD_LOAD, n == 0, t_onset, pick_tempo(), 0, tr);
                if ($urandom_range(0, 9) == 0)
                    t_onset = $urandom;
                else
                    t_onset = t_onset + $urandom_range(0, 3000);
            end

            // Event pass, mostly ascending, with stray noise items
            n = $urandom_range(3, 25);
            t_onset = $urandom_range(0, 800);
            for (int k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 11))
                    0: send_item(CMD_EVENT, $urandom_range(0, 1), $urandom,
                                 24'($urandom), 0, tr);
                    1: send_item(CMD_EVENT, 0, t_onset - $urandom_range(1, 400),
                                 0, 0, tr);
                    2: send_item(CMD_LOAD, 0, $urandom, pick_tempo(), 0, tr);
                    default:
                    begin
                        send_item(CMD_EVENT, k == 0, t_onset, 24'($urandom), 0, tr);
                        t_onset = t_onset + $urandom_range(0, 2500);
                    end
                endcase
            end

            // Let the block drain completely now and then
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/tmtd_pkg.sv
rtl/core/tmtd_ctrl.sv
rtl/core/tmtd_datapath.sv
rtl/core/tempo_map_tick_to_delta_ms.sv
tb/sv/tempo_map_tick_to_delta_ms_tb.sv
